// ----- rtl/core/wvr_pkg.sv -----
// Shared constants for the world-to-vehicle frame rotator.
// Binary-angle widths, CORDIC arctangent table and gain constant.
// No dependencies.
`default_nettype none

package wvr_pkg;

	// heading input and angle accumulator widths
	localparam int ANGLE_W = 16;
	localparam int Z_W     = 32;
	localparam int ATAN_N  = 32;

	// 1/K (limit gain compensation) in Q0.32
	localparam logic [63:0] GAIN_Q32 = 64'd2608131496;

	typedef logic signed [Z_W-1:0] zval_t;

	// round(atan(2^-i) * 2^32 / (2*pi))
	localparam zval_t ATAN_TAB [ATAN_N] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
		32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
		32'sd652,       32'sd326,       32'sd163,       32'sd81,
		32'sd41,        32'sd20,        32'sd10,        32'sd5,
		32'sd3,         32'sd1,         32'sd1,         32'sd0
	};

endpackage

`default_nettype wire

// ----- rtl/core/wvr_cordic_stage.sv -----
// One registered CORDIC micro-rotation (rotation mode, fixed shift IDX).
// Depends on wvr_pkg for the arctangent table.
`default_nettype none

module wvr_cordic_stage
	import wvr_pkg::*;
#(
	parameter int XW  = 64,
	parameter int IDX = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 vld_i,
	input  wire logic signed [XW-1:0] x_i,
	input  wire logic signed [XW-1:0] y_i,
	input  wire zval_t                z_i,
	output logic                      vld_s,
	output logic signed [XW-1:0]      x_s,
	output logic signed [XW-1:0]      y_s,
	output zval_t                     z_s
);

	logic signed [XW-1:0] xsh, ysh;
	logic                 pos;

	assign xsh = x_i >>> IDX;
	assign ysh = y_i >>> IDX;
	assign pos = ~z_i[Z_W-1];   // zero turns positive

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (en) begin
			vld_s <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pos) begin
				x_s <= x_i - ysh;
				y_s <= y_i + xsh;
				z_s <= z_i - ATAN_TAB[IDX];
			end else begin
				x_s <= x_i + ysh;
				y_s <= y_i - xsh;
				z_s <= z_i + ATAN_TAB[IDX];
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/world_to_vehicle_frame_rotate.sv -----
// World-to-vehicle frame rotation: offset from origin, turned by -heading.
// Stages in order: offsets and angle split, quarter turns, gain, CORDIC chain, round and clamp.
// Throughput one item per cycle while in_stall is low: every stage is registered, no loop back.
// in_stall rises only while the output skid register holds a stalled item.
// Reset (arst_n, async, active low) clears valid bits and the skid flag only.
// Depends on wvr_pkg and wvr_cordic_stage.
`default_nettype none

module world_to_vehicle_frame_rotate
	import wvr_pkg::*;
#(
	parameter int CORDIC_STAGES = 16,
	parameter int COORD_WIDTH   = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [COORD_WIDTH-1:0] point_east,
	input  wire logic signed [COORD_WIDTH-1:0] point_north,
	input  wire logic signed [COORD_WIDTH-1:0] origin_east,
	input  wire logic signed [COORD_WIDTH-1:0] origin_north,
	input  wire logic        [ANGLE_W-1:0]     heading_angle,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0]      forward_pos,
	output logic signed [COORD_WIDTH-1:0]      lateral_pos,
	output logic                               saturated
);

	// fraction bits of the gain-compensated datapath
	localparam int KSHIFT = ((61 - COORD_WIDTH) > 32) ? 32 : (61 - COORD_WIDTH);
	localparam int KRED   = 32 - KSHIFT;
	localparam logic [63:0] GAIN_RND = (KRED == 0) ? GAIN_Q32 :
		((GAIN_Q32 + (64'd1 << ((KRED == 0) ? 0 : (KRED - 1)))) >> KRED);
	localparam logic signed [KSHIFT:0] GAIN_OP = {1'b0, GAIN_RND[KSHIFT-1:0]};

	localparam int DW = COORD_WIDTH + 2;          // offset after a quadrant turn
	localparam int XW = DW + KSHIFT + 1;          // scaled CORDIC vector
	localparam int RW = XW - KSHIFT;              // after rounding shift
	localparam int CW = COORD_WIDTH;

	// global advance; the skid register absorbs the one item in flight
	logic en;
	logic skid_full_q;

	assign en       = ~skid_full_q;
	assign in_stall = skid_full_q;

	// ---- stage 1: offsets and angle split ----
	// phi = -heading; t = phi + 1/8 turn picks the quadrant, the low 14 bits
	// minus 1/8 turn give a residual in [-1/8, 1/8) turn, scaled to 2^32/turn.
	logic [ANGLE_W-1:0]   phi, tang;
	logic                 vld_s1;
	logic signed [CW:0]   de_s1, dn_s1;
	logic [1:0]           quad_s1;
	zval_t                z_s1;

	assign phi  = ANGLE_W'(0) - heading_angle;
	assign tang = phi + ANGLE_W'(16'h2000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			de_s1   <= {point_east[CW-1], point_east} - {origin_east[CW-1], origin_east};
			dn_s1   <= {point_north[CW-1], point_north} - {origin_north[CW-1], origin_north};
			quad_s1 <= tang[15:14];
			z_s1    <= {{3{~tang[13]}}, tang[12:0], 16'h0000};
		end
	end

	// ---- stage 2: exact quarter turns ----
	logic                 vld_s2;
	logic signed [DW-1:0] x_s2, y_s2;
	zval_t                z_s2;
	logic signed [DW-1:0] de_x, dn_x;

	assign de_x = DW'(de_s1);
	assign dn_x = DW'(dn_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2 <= z_s1;
			case (quad_s1)
				2'd0: begin
					x_s2 <= de_x;
					y_s2 <= dn_x;
				end
				2'd1: begin
					x_s2 <= -dn_x;
					y_s2 <= de_x;
				end
				2'd2: begin
					x_s2 <= -de_x;
					y_s2 <= -dn_x;
				end
				default: begin
					x_s2 <= dn_x;
					y_s2 <= -de_x;
				end
			endcase
		end
	end

	// ---- stage 3: gain compensation ----
	logic                 vld_s3;
	logic signed [XW-1:0] x_s3, y_s3;
	zval_t                z_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3 <= XW'(x_s2) * XW'(GAIN_OP);
			y_s3 <= XW'(y_s2) * XW'(GAIN_OP);
			z_s3 <= z_s2;
		end
	end

	// ---- CORDIC chain, one micro-rotation per stage ----
	logic                 vld_c [CORDIC_STAGES+1];
	logic signed [XW-1:0] x_c   [CORDIC_STAGES+1];
	logic signed [XW-1:0] y_c   [CORDIC_STAGES+1];
	zval_t                z_c   [CORDIC_STAGES+1];

	assign vld_c[0] = vld_s3;
	assign x_c[0]   = x_s3;
	assign y_c[0]   = y_s3;
	assign z_c[0]   = z_s3;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
		wvr_cordic_stage #(
			.XW  (XW),
			.IDX (g)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld_c[g]),
			.x_i    (x_c[g]),
			.y_i    (y_c[g]),
			.z_i    (z_c[g]),
			.vld_s  (vld_c[g+1]),
			.x_s    (x_c[g+1]),
			.y_s    (y_c[g+1]),
			.z_s    (z_c[g+1])
		);
	end

	// ---- final stage: round half up, clamp ----
	// In range when the bits above the result's sign all copy it.
	logic signed [XW-1:0] xr, yr;
	logic signed [RW-1:0] xq, yq;
	logic                 x_ovf, y_ovf;
	logic [CW-1:0]        x_sat, y_sat;

	assign xr = x_c[CORDIC_STAGES] + (XW'(1) <<< (KSHIFT - 1));
	assign yr = y_c[CORDIC_STAGES] + (XW'(1) <<< (KSHIFT - 1));
	assign xq = xr[XW-1:KSHIFT];
	assign yq = yr[XW-1:KSHIFT];

	assign x_ovf = ~((&xq[RW-1:CW-1]) | ~(|xq[RW-1:CW-1]));
	assign y_ovf = ~((&yq[RW-1:CW-1]) | ~(|yq[RW-1:CW-1]));
	assign x_sat = x_ovf ? {xq[RW-1], {(CW-1){~xq[RW-1]}}} : xq[CW-1:0];
	assign y_sat = y_ovf ? {yq[RW-1], {(CW-1){~yq[RW-1]}}} : yq[CW-1:0];

	logic          vld_s4;
	logic [CW-1:0] fwd_s4, lat_s4;
	logic          sat_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_c[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fwd_s4 <= x_sat;
			lat_s4 <= y_sat;
			sat_s4 <= x_ovf | y_ovf;
		end
	end

	// ---- output skid ----
	// A stalled item in the last stage moves here while the pipe advances
	// once more; the pipe then holds until the skid item is taken.
	logic [CW-1:0] fwd_q, lat_q;
	logic          sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (!out_stall) begin
				skid_full_q <= 1'b0;
			end
		end else if (vld_s4 && out_stall) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && vld_s4 && out_stall) begin
			fwd_q <= fwd_s4;
			lat_q <= lat_s4;
			sat_q <= sat_s4;
		end
	end

	assign out_valid   = skid_full_q | vld_s4;
	assign forward_pos = skid_full_q ? fwd_q : fwd_s4;
	assign lateral_pos = skid_full_q ? lat_q : lat_s4;
	assign saturated   = skid_full_q ? sat_q : sat_s4;

endmodule

`default_nettype wire
